// ----- hw/rtl/rtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcc_pkg
// Types, limits and the month-length function shared by the 12-hour
// real-time clock and calendar.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  // Complete time and date as held by the clock.
  typedef struct packed {
    logic [3:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        pm;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } rtcc_cal_t;

  localparam logic        CMD_TICK   = 1'b0;
  localparam logic        CMD_LOAD   = 1'b1;

  localparam logic [5:0]  SEC_MAX    = 6'd59;
  localparam logic [5:0]  MIN_MAX    = 6'd59;
  localparam logic [3:0]  HOUR_MAX   = 4'd11;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_APR  = 4'd4;
  localparam logic [3:0]  MONTH_JUN  = 4'd6;
  localparam logic [3:0]  MONTH_SEP  = 4'd9;
  localparam logic [3:0]  MONTH_NOV  = 4'd11;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2010;

  localparam logic [4:0]  DAYS_LONG  = 5'd31;
  localparam logic [4:0]  DAYS_SHORT = 5'd30;
  localparam logic [4:0]  DAYS_FEB   = 5'd28;
  localparam logic [4:0]  DAYS_LEAP  = 5'd29;

  // Every fourth year is a leap year, year 0 included.
  function automatic logic is_leap(input logic [13:0] yr);
    is_leap = (yr[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    case (mon)
      MONTH_FEB: month_len = leap ? DAYS_LEAP : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = DAYS_SHORT;
      default: month_len = DAYS_LONG;
    endcase
  endfunction

endpackage

// ----- hw/rtl/rtcc_tick.sv -----
// ----------------------------------------------------------------------------
// rtcc_tick
// Advances the held time and date by one second, with the carry chain
// through the half-day flag, day, month and year.
// ----------------------------------------------------------------------------
module rtcc_tick (
  input  rtcc_pkg::rtcc_cal_t cur,
  output rtcc_pkg::rtcc_cal_t nxt
);

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic [4:0] days_in_month;

  assign sec_wrap      = (cur.second >= rtcc_pkg::SEC_MAX);
  assign min_wrap      = sec_wrap && (cur.minute >= rtcc_pkg::MIN_MAX);
  assign hour_wrap     = min_wrap && (cur.hour >= rtcc_pkg::HOUR_MAX);
  assign days_in_month = rtcc_pkg::month_len(cur.month, rtcc_pkg::is_leap(cur.year));
  // The date only moves when the half-day flag returns from PM to AM.
  assign day_wrap      = hour_wrap && cur.pm && (cur.day >= days_in_month);
  assign month_wrap    = day_wrap && (cur.month >= rtcc_pkg::MONTH_DEC);

  always_comb begin
    nxt = cur;
    nxt.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
    if (sec_wrap) begin
      nxt.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
    end
    if (min_wrap) begin
      nxt.hour = hour_wrap ? 4'd0 : cur.hour + 4'd1;
    end
    if (hour_wrap) begin
      nxt.pm = ~cur.pm;
      if (cur.pm) begin
        nxt.day = day_wrap ? rtcc_pkg::DAY_FIRST : cur.day + 5'd1;
      end
    end
    if (day_wrap) begin
      nxt.month = month_wrap ? rtcc_pkg::MONTH_JAN : cur.month + 4'd1;
    end
    if (month_wrap) begin
      nxt.year = (cur.year >= rtcc_pkg::YEAR_MAX) ? 14'd0 : cur.year + 14'd1;
    end
  end

endmodule

// ----- hw/rtl/rtcc_load.sv -----
// ----------------------------------------------------------------------------
// rtcc_load
// Range check of a requested time and date; the checked value is offered
// together with a flag saying whether it may be taken.
// ----------------------------------------------------------------------------
module rtcc_load (
  input  logic [3:0]          set_hour,
  input  logic [5:0]          set_minute,
  input  logic [5:0]          set_second,
  input  logic                set_pm,
  input  logic [4:0]          set_day,
  input  logic [3:0]          set_month,
  input  logic [13:0]         set_year,
  output rtcc_pkg::rtcc_cal_t cand,
  output logic                ok
);

  logic [4:0] days_in_month;

  assign days_in_month = rtcc_pkg::month_len(set_month, rtcc_pkg::is_leap(set_year));

  assign ok = (set_hour <= rtcc_pkg::HOUR_MAX) && (set_minute <= rtcc_pkg::MIN_MAX) &&
              (set_second <= rtcc_pkg::SEC_MAX) && (set_month >= rtcc_pkg::MONTH_JAN) &&
              (set_month <= rtcc_pkg::MONTH_DEC) && (set_year <= rtcc_pkg::YEAR_MAX) &&
              (set_day >= rtcc_pkg::DAY_FIRST) && (set_day <= days_in_month);

  always_comb begin
    cand.hour   = set_hour;
    cand.minute = set_minute;
    cand.second = set_second;
    cand.pm     = set_pm;
    cand.day    = set_day;
    cand.month  = set_month;
    cand.year   = set_year;
  end

endmodule

// ----- hw/rtl/rtc_calendar_12h.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_12h
// Real-time clock and calendar in 12-hour form with tick and load words.
// ----------------------------------------------------------------------------
// Each input word is either a one-second tick or a load of time and date, and
// each produces exactly one result word showing the time and date after it.
// A word is captured in the input register, goes through the update logic
// and lands in the output register once the result side has room, and a new
// word is taken every cycle while the result side keeps up; the single held
// calendar state, updated in that one pass, sets this rate.
// Out-of-range loads leave the calendar untouched and raise load_rejected.
// After reset the clock reads 00:00:00 AM, 1 January 2010.
module rtc_calendar_12h (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [3:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  input  logic        in_set_pm,
  input  logic [4:0]  in_set_day,
  input  logic [3:0]  in_set_month,
  input  logic [13:0] in_set_year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_is_pm,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic        out_load_rejected
);

  // Input register.
  logic        in_v_r;
  logic        cmd_r;
  logic [3:0]  set_hour_r;
  logic [5:0]  set_minute_r;
  logic [5:0]  set_second_r;
  logic        set_pm_r;
  logic [4:0]  set_day_r;
  logic [3:0]  set_month_r;
  logic [13:0] set_year_r;

  rtcc_pkg::rtcc_cal_t cal_r;
  rtcc_pkg::rtcc_cal_t cal_nxt;
  rtcc_pkg::rtcc_cal_t tick_cal;
  rtcc_pkg::rtcc_cal_t load_cal;
  logic                load_ok;
  logic                rejected_nxt;

  // Output register.
  logic                out_v_r;
  rtcc_pkg::rtcc_cal_t res_r;
  logic                rej_r;

  logic advance;
  logic in_take;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;
  assign in_take  = in_valid && in_ready;

  rtcc_tick u_tick (
    .cur (cal_r),
    .nxt (tick_cal)
  );

  rtcc_load u_load (
    .set_hour   (set_hour_r),
    .set_minute (set_minute_r),
    .set_second (set_second_r),
    .set_pm     (set_pm_r),
    .set_day    (set_day_r),
    .set_month  (set_month_r),
    .set_year   (set_year_r),
    .cand       (load_cal),
    .ok         (load_ok)
  );

  always_comb begin
    if (cmd_r == rtcc_pkg::CMD_LOAD) begin
      cal_nxt      = load_ok ? load_cal : cal_r;
      rejected_nxt = !load_ok;
    end else begin
      cal_nxt      = tick_cal;
      rejected_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cal_r.hour   <= 4'd0;
      cal_r.minute <= 6'd0;
      cal_r.second <= 6'd0;
      cal_r.pm     <= 1'b0;
      cal_r.day    <= rtcc_pkg::DAY_FIRST;
      cal_r.month  <= rtcc_pkg::MONTH_JAN;
      cal_r.year   <= rtcc_pkg::YEAR_RESET;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        cal_r   <= cal_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r        <= in_cmd;
      set_hour_r   <= in_set_hour;
      set_minute_r <= in_set_minute;
      set_second_r <= in_set_second;
      set_pm_r     <= in_set_pm;
      set_day_r    <= in_set_day;
      set_month_r  <= in_set_month;
      set_year_r   <= in_set_year;
    end
    if (advance) begin
      res_r <= cal_nxt;
      rej_r <= rejected_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_hour          = res_r.hour;
  assign out_minute        = res_r.minute;
  assign out_second        = res_r.second;
  assign out_is_pm         = res_r.pm;
  assign out_day           = res_r.day;
  assign out_month         = res_r.month;
  assign out_year          = res_r.year;
  assign out_load_rejected = rej_r;

endmodule
